@@ hdl/satq_pkg.sv @@
// Shared types and constants for the sorted alarm timer queue.
package satq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int TAG_W           = 8;
    localparam int DELAY_W         = 16;
    localparam int STATUS_W        = 2;
    localparam int MAX_FIRE        = 16;
    localparam int FIRE_W          = $clog2(MAX_FIRE);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FIRED     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DELAY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } op_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_INSERT,
        FSM_DRAIN
    } fsm_t;

    // what a cell tells its neighbors
    typedef struct packed {
        logic valid;
        logic due;      // valid and deadline not later than the key
    } link_t;

endpackage

@@ hdl/sorted_alarm_timer_queue_core.sv @@
// Top level of the sorted alarm timer queue: command sequencer, cell row, result register.
//
//  channel | dir | tdata                          | tuser       | tlast
//  s_      | in  | [15:0] delay_seconds, [23:16]  | [0] command | -
//          |     |        alarm_id                |             |
//  m_      | out | [7:0] alarm_id_out             | [1:0] status| last
//
// An insert first computes deadline = now + delay, then does the
// compare-and-shift in the cell row. A tick fires the due alarms, up to
// 16, with a one-entry pop per cycle at the queue head while the m_ side
// is not stalled.
// Synchronous active-low reset clears the queue and time; no clearing pass.
// A stalled m_ side holds the sequencer; s_tready is high only when idle.
module sorted_alarm_timer_queue_core #(
    parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = satq_pkg::TIME_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] delay_seconds, [23:16] alarm_id
    input  logic [0:0]  s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] alarm_id_out
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    satq_pkg::fsm_t state_reg, state_next;
    logic [TIME_WIDTH-1:0]            time_reg, time_next;
    logic [TIME_WIDTH-1:0]            key_reg, key_next;
    logic [satq_pkg::TAG_W-1:0]       id_reg, id_next;
    logic                             zero_reg, zero_next;
    logic [satq_pkg::FIRE_W-1:0]      cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic [satq_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [satq_pkg::TAG_W-1:0]       out_id_reg, out_id_next;
    logic                             out_last_reg, out_last_next;

    logic                             accept, out_free, full, due0, due1, last_fire;
    logic                             emit;
    logic [satq_pkg::STATUS_W-1:0]    emit_status;
    logic [satq_pkg::TAG_W-1:0]       emit_id;
    logic                             emit_last;
    satq_pkg::op_t                    op;

    satq_pkg::link_t                  links [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0]            dls   [QUEUE_DEPTH];
    logic [satq_pkg::TAG_W-1:0]       tags  [QUEUE_DEPTH];

    assign s_tready = (state_reg == satq_pkg::FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign full     = links[QUEUE_DEPTH-1].valid;
    assign due0     = links[0].due;
    assign due1     = links[1].due;
    assign last_fire = !due1 || (cnt_reg == satq_pkg::FIRE_W'(satq_pkg::MAX_FIRE - 1));

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            satq_pkg::link_t            l_link, r_link;
            logic [TIME_WIDTH-1:0]      l_dl, r_dl;
            logic [satq_pkg::TAG_W-1:0] l_tag, r_tag;
            if (i == 0) begin : g_head
                assign l_link = '{valid: 1'b0, due: 1'b1};
                assign l_dl   = '0;
                assign l_tag  = '0;
            end else begin : g_mid
                assign l_link = links[i-1];
                assign l_dl   = dls[i-1];
                assign l_tag  = tags[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign r_link = '{valid: 1'b0, due: 1'b0};
                assign r_dl   = '0;
                assign r_tag  = '0;
            end else begin : g_body
                assign r_link = links[i+1];
                assign r_dl   = dls[i+1];
                assign r_tag  = tags[i+1];
            end
            satq_cell #(
                .TIME_WIDTH(TIME_WIDTH)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .op            (op),
                .key           (key_reg),
                .ins_tag       (id_reg),
                .left_link     (l_link),
                .left_deadline (l_dl),
                .left_tag      (l_tag),
                .right_link    (r_link),
                .right_deadline(r_dl),
                .right_tag     (r_tag),
                .link          (links[i]),
                .deadline      (dls[i]),
                .tag           (tags[i])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            satq_pkg::FSM_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser[0] == satq_pkg::CMD_TICK) ?
                                 satq_pkg::FSM_DRAIN : satq_pkg::FSM_INSERT;
                end
            end
            satq_pkg::FSM_INSERT: begin
                if (out_free) begin
                    state_next = satq_pkg::FSM_IDLE;
                end
            end
            satq_pkg::FSM_DRAIN: begin
                if (!due0) begin
                    state_next = satq_pkg::FSM_IDLE;
                end else if (out_free && last_fire) begin
                    state_next = satq_pkg::FSM_IDLE;
                end
            end
            default: state_next = satq_pkg::FSM_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        op          = satq_pkg::OP_HOLD;
        emit        = 1'b0;
        emit_status = satq_pkg::ST_FIRED;
        emit_id     = id_reg;
        emit_last   = 1'b1;
        case (state_reg)
            satq_pkg::FSM_INSERT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (zero_reg) begin
                        emit_status = satq_pkg::ST_BAD_DELAY;
                    end else if (full) begin
                        emit_status = satq_pkg::ST_FULL;
                    end else begin
                        emit_status = satq_pkg::ST_ACCEPTED;
                        op          = satq_pkg::OP_INSERT;
                    end
                end
            end
            satq_pkg::FSM_DRAIN: begin
                if (due0 && out_free) begin
                    emit        = 1'b1;
                    emit_status = satq_pkg::ST_FIRED;
                    emit_id     = tags[0];
                    emit_last   = last_fire;
                    op          = satq_pkg::OP_POP;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        time_next = time_reg;
        key_next  = key_reg;
        id_next   = id_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            cnt_next = '0;
            if (s_tuser[0] == satq_pkg::CMD_TICK) begin
                time_next = time_reg + TIME_WIDTH'(1);
                key_next  = time_reg + TIME_WIDTH'(1);
            end else begin
                key_next  = time_reg + TIME_WIDTH'(s_tdata[15:0]);
                id_next   = s_tdata[23:16];
                zero_next = (s_tdata[15:0] == '0);
            end
        end else if (emit && state_reg == satq_pkg::FSM_DRAIN) begin
            cnt_next = cnt_reg + satq_pkg::FIRE_W'(1);
        end
    end

    // result register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        if (emit) begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_id_next     = emit_id;
            out_last_next   = emit_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= satq_pkg::FSM_IDLE;
            time_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        key_reg        <= key_next;
        id_reg         <= id_next;
        zero_reg       <= zero_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hdl/satq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
module satq_cell #(
    parameter int TIME_WIDTH = satq_pkg::TIME_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  satq_pkg::op_t              op,
    input  logic [TIME_WIDTH-1:0]      key,
    input  logic [satq_pkg::TAG_W-1:0] ins_tag,
    input  satq_pkg::link_t            left_link,
    input  logic [TIME_WIDTH-1:0]      left_deadline,
    input  logic [satq_pkg::TAG_W-1:0] left_tag,
    input  satq_pkg::link_t            right_link,
    input  logic [TIME_WIDTH-1:0]      right_deadline,
    input  logic [satq_pkg::TAG_W-1:0] right_tag,
    output satq_pkg::link_t            link,
    output logic [TIME_WIDTH-1:0]      deadline,
    output logic [satq_pkg::TAG_W-1:0] tag
);

    logic                       valid_reg, valid_next;
    logic [TIME_WIDTH-1:0]      deadline_reg, deadline_next;
    logic [satq_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [TIME_WIDTH-1:0]      diff;
    logic                       later;

    // wrap-aware: strictly later when the signed difference is positive
    assign diff  = deadline_reg - key;
    assign later = (diff != '0) && !diff[TIME_WIDTH-1];

    assign link.valid = valid_reg;
    assign link.due   = valid_reg && !later;
    assign deadline   = deadline_reg;
    assign tag        = tag_reg;

    always_comb begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        tag_next      = tag_reg;
        case (op)
            satq_pkg::OP_INSERT: begin
                if (!link.due) begin
                    if (left_link.due) begin
                        valid_next    = 1'b1;
                        deadline_next = key;
                        tag_next      = ins_tag;
                    end else begin
                        valid_next    = left_link.valid;
                        deadline_next = left_deadline;
                        tag_next      = left_tag;
                    end
                end
            end
            satq_pkg::OP_POP: begin
                valid_next    = right_link.valid;
                deadline_next = right_deadline;
                tag_next      = right_tag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        deadline_reg <= deadline_next;
        tag_reg      <= tag_next;
    end

endmodule

@@ hdl/satq_checker.sv @@
// Port-level checks for the sorted alarm timer queue, bound to the top level.
module satq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // insert results are always single beats
    a_insert_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != satq_pkg::ST_FIRED) |-> m_tlast)
        else $error("insert result without tlast");

    // one command at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a command is in progress");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not cleared by reset");

endmodule

bind sorted_alarm_timer_queue_core satq_checker u_satq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

@@ sim/testbench.sv @@
// Testbench for the sorted alarm timer queue: directed table, random alarm traffic, result check.
module testbench;
    import satq_pkg::*;

    localparam int TW          = TIME_WIDTH_DEF;
    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int ITEM_TARGET = 310;
    localparam int STALL_LIMIT = 3000;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } alarm_result_t;

    typedef struct packed {
        logic [TW-1:0]    deadline;
        logic [TAG_W-1:0] tag;
    } alarm_entry_t;

    typedef struct {
        logic                cmd;
        logic [DELAY_W-1:0]  delay;
        logic [TAG_W-1:0]    tag;
        bit                  typed;   // expected status written in the row
        logic [STATUS_W-1:0] status;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] delay_seconds, [23:16] alarm_id
    logic [0:0]  s_tuser;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // [7:0] alarm_id_out
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;

    sorted_alarm_timer_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    alarm_entry_t  pending_alarms[$];
    logic [TW-1:0] clock_ticks;
    alarm_result_t results_due[$];

    int error_count     = 0;
    int items_sent      = 0;
    int beats_checked   = 0;
    int alarms_fired    = 0;
    int inserts_refused = 0;
    int deepest_queue   = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;
    int ready_cycle     = 0;
    int ready_mode      = 0;

    directed_row_t directed_rows [N_DIRECTED];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic log_fault(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // a is strictly later than b, by wrap-aware signed difference
    function automatic bit deadline_later(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] d;
        d = a - b;
        return (d != '0) && !d[TW-1];
    endfunction

    task automatic step_alarm_model(input logic cmd, input logic [DELAY_W-1:0] delay,
                                    input logic [TAG_W-1:0] tag,
                                    output alarm_result_t res [MAX_FIRE], output int n_res);
        logic [TW-1:0] deadline;
        int pos;
        n_res = 0;
        if (cmd == CMD_INSERT) begin
            if (delay == '0) begin
                res[0] = '{ST_BAD_DELAY, tag, 1'b1};
                inserts_refused++;
            end else if (pending_alarms.size() >= DEPTH) begin
                res[0] = '{ST_FULL, tag, 1'b1};
                inserts_refused++;
            end else begin
                deadline = clock_ticks + TW'(delay);
                pos = 0;
                // equal deadlines stay behind earlier arrivals
                while (pos < pending_alarms.size() &&
                       !deadline_later(pending_alarms[pos].deadline, deadline))
                    pos++;
                pending_alarms.insert(pos, '{deadline, tag});
                res[0] = '{ST_ACCEPTED, tag, 1'b1};
                if (pending_alarms.size() > deepest_queue)
                    deepest_queue = pending_alarms.size();
            end
            n_res = 1;
        end else begin
            clock_ticks = clock_ticks + TW'(1);
            while (n_res < MAX_FIRE && pending_alarms.size() > 0 &&
                   !deadline_later(pending_alarms[0].deadline, clock_ticks)) begin
                res[n_res] = '{ST_FIRED, pending_alarms[0].tag, 1'b0};
                void'(pending_alarms.pop_front());
                n_res++;
            end
            if (n_res > 0)
                res[n_res-1].last = 1'b1;
            alarms_fired += n_res;
        end
    endtask

    task automatic send_item(input logic cmd, input logic [DELAY_W-1:0] delay,
                             input logic [TAG_W-1:0] tag, input bit typed,
                             input logic [STATUS_W-1:0] typed_status);
        alarm_result_t res [MAX_FIRE];
        int n_res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {tag, delay};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        step_alarm_model(cmd, delay, tag, res, n_res);
        if (typed)
            results_due.push_back('{typed_status, tag, 1'b1});
        else
            for (int i = 0; i < n_res; i++)
                results_due.push_back(res[i]);
    endtask

    task automatic send_insert(input logic [DELAY_W-1:0] delay);
        send_item(CMD_INSERT, delay, TAG_W'($urandom_range(0, 255)), 1'b0, ST_ACCEPTED);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, DELAY_W'($urandom_range(0, 65535)), TAG_W'($urandom_range(0, 255)),
                  1'b0, ST_FIRED);
    endtask

    // receiver back-pressure: always ready, random, or a repeating duty pattern, re-chosen at random
    always @(negedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 60 == 0)
            ready_mode = $urandom_range(0, 2);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (ready_cycle % 5) < 2;
        endcase
    end

    always @(posedge aclk) begin
        alarm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (results_due.size() == 0) begin
                log_fault($sformatf("unexpected beat status=%0d id=%02h last=%0b",
                                    m_tuser, m_tdata, m_tlast));
            end else begin
                want = results_due.pop_front();
                if (m_tuser !== want.status)
                    log_fault($sformatf("status %0d, want %0d", m_tuser, want.status));
                if (m_tdata !== want.tag)
                    log_fault($sformatf("alarm id %02h, want %02h", m_tdata, want.tag));
                if (m_tlast !== want.last)
                    log_fault($sformatf("last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, results_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int pick;
        int n;
        int d;
        int r;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        clock_ticks = '0;

        directed_rows = '{
            '{CMD_TICK,   16'd0,      8'h00, 1'b0, ST_FIRED},     // tick with nothing due
            '{CMD_INSERT, 16'd0,      8'hFF, 1'b1, ST_BAD_DELAY},
            '{CMD_INSERT, 16'hFFFF,   8'h00, 1'b1, ST_ACCEPTED},
            '{CMD_INSERT, 16'd1,      8'hA5, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd1,      8'h5A, 1'b0, ST_ACCEPTED},  // same deadline, FIFO
            '{CMD_INSERT, 16'd3,      8'h11, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd2,      8'h22, 1'b0, ST_ACCEPTED},  // goes ahead of later one
            '{CMD_INSERT, 16'h8000,   8'h80, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd1,      8'h33, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd4,      8'h44, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd2,      8'h55, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd5,      8'h66, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd1,      8'hC3, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd6,      8'h3C, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd2,      8'h96, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd3,      8'h69, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd4,      8'hF0, 1'b0, ST_ACCEPTED},
            '{CMD_INSERT, 16'd1,      8'h0F, 1'b0, ST_ACCEPTED},  // queue now full
            '{CMD_INSERT, 16'd7,      8'h77, 1'b1, ST_FULL},
            '{CMD_INSERT, 16'd0,      8'h01, 1'b1, ST_BAD_DELAY}, // zero delay wins over full
            '{CMD_TICK,   16'hFFFF,   8'hFF, 1'b0, ST_FIRED},     // five due at once
            '{CMD_TICK,   16'h5555,   8'hAA, 1'b0, ST_FIRED},
            '{CMD_TICK,   16'hAAAA,   8'h55, 1'b0, ST_FIRED},
            '{CMD_TICK,   16'h0000,   8'h00, 1'b0, ST_FIRED}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].delay, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].status);

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                // batch on one deadline, then tick until it has fired
                d = $urandom_range(1, 6);
                n = $urandom_range(2, 8);
                repeat (n) send_insert(DELAY_W'(d));
                repeat (d + 1) send_tick();
            end else if (pick < 6) begin
                send_tick();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_insert('0);
                else if (r < 8)
                    send_insert(DELAY_W'($urandom_range(0, 65535)));
                else if (r < 15)
                    send_insert(DELAY_W'($urandom_range(16, 300)));
                else
                    send_insert(DELAY_W'($urandom_range(1, 12)));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("ran %0d commands (%0d from the table), checked %0d result beats",
                 items_sent, N_DIRECTED, beats_checked);
        $display("%0d alarms fired, %0d inserts refused, queue peaked at %0d of %0d",
                 alarms_fired, inserts_refused, deepest_queue, DEPTH);
        if (error_count == 0 && results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/satq_pkg.sv
hdl/satq_cell.sv
hdl/sorted_alarm_timer_queue_core.sv
hdl/satq_checker.sv
sim/testbench.sv
